FILE: design/assert_macros.svh
// assertion helpers used by the checker in olids_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define OLIDS_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("olids assertion failed");

// same, on the usual clock and reset names
`define OLIDS_ASSERT(name, prop) \
  `OLIDS_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

FILE: design/olids_pkg.sv
`timescale 1ns / 1ps

package olids_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_LOCATE = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_DELETE = 3'd4,
    MODE_READ   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APP_WR,
    S_LOC_RD,
    S_LOC_CMP,
    S_INS_CHK,
    S_INS_MOV,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_MOV,
    S_RD_RD,
    S_RD_CAP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    LEN_HOLD,
    LEN_CLEAR,
    LEN_INC,
    LEN_DEC
  } len_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LEN,
    IDX_POSM1,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDXP1,
    RA_IDXM1
  } rd_sel_e;

  typedef enum logic {
    WD_VAL,
    WD_RDATA
  } wd_sel_e;

  typedef struct packed {
    logic    load;
    len_op_e len_op;
    idx_op_e idx_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wd_sel_e wd_sel;
    logic    set_status;
    status_e status;
    logic    set_found;
    logic    set_data;
    logic    push;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  ins_bad;
    logic  acc_bad;
    logic  len_zero;
    logic  last;
    logic  at_pos;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

FILE: design/olids_in_if.sv
`timescale 1ns / 1ps

interface olids_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic        [6:0]  position;
  logic signed [31:0] item_value;

  modport source (output valid, output mode, output position, output item_value,
                  input ready);
  modport sink (input valid, input mode, input position, input item_value,
                output ready);
endinterface

FILE: design/olids_out_if.sv
`timescale 1ns / 1ps

interface olids_out_if;
  logic               valid;
  logic               ready;
  logic        [6:0]  found_position;
  logic signed [31:0] data_out;
  logic        [6:0]  list_count;
  logic        [1:0]  status;

  modport source (output valid, output found_position, output data_out,
                  output list_count, output status, input ready);
  modport sink (input valid, input found_position, input data_out,
                input list_count, input status, output ready);
endinterface

FILE: design/olids_ctrl.sv
`timescale 1ns / 1ps

module olids_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  olids_pkg::sts_t  sts_i,
  output olids_pkg::cmd_t  cmd_o
);
  import olids_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.len_op     = LEN_HOLD;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.rd_sel     = RA_IDX;
    cmd_o.wd_sel     = WD_VAL;
    cmd_o.status     = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.mode)
          MODE_CLEAR: begin
            cmd_o.len_op = LEN_CLEAR;
            state_d      = S_DONE;
          end
          MODE_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d          = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_LEN;
              state_d      = S_APP_WR;
            end
          end
          MODE_LOCATE: begin
            if (sts_i.len_zero) begin
              state_d = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_LOC_RD;
            end
          end
          MODE_INSERT: begin
            priority if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d          = S_DONE;
            end else if (sts_i.ins_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
              state_d          = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_LEN;
              state_d      = S_INS_CHK;
            end
          end
          MODE_DELETE: begin
            if (sts_i.acc_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
              state_d          = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_POSM1;
              state_d      = S_DEL_RD;
            end
          end
          MODE_READ: begin
            if (sts_i.acc_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
              state_d          = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_POSM1;
              state_d      = S_RD_RD;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_APP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_VAL;
        cmd_o.len_op = LEN_INC;
        state_d      = S_DONE;
      end
      S_LOC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX;
        state_d      = S_LOC_CMP;
      end
      S_LOC_CMP: begin
        priority if (sts_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_DONE;
        end else if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_LOC_RD;
        end
      end
      S_INS_CHK: begin
        if (sts_i.at_pos) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wd_sel = WD_VAL;
          cmd_o.len_op = LEN_INC;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDXM1;
          state_d      = S_INS_MOV;
        end
      end
      S_INS_MOV: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_INS_CHK;
      end
      S_DEL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX;
        state_d      = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd_o.set_data = 1'b1;
        state_d        = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.last) begin
          cmd_o.len_op = LEN_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDXP1;
          state_d      = S_DEL_MOV;
        end
      end
      S_DEL_MOV: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DEL_CHK;
      end
      S_RD_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX;
        state_d      = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd_o.set_data = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/olids_dp.sv
`timescale 1ns / 1ps

module olids_dp #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  olids_pkg::cmd_t    cmd_i,
  output olids_pkg::sts_t    sts_o,
  input  logic        [2:0]  mode_i,
  input  logic        [6:0]  position_i,
  input  logic signed [31:0] item_value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic        [6:0]  found_position_o,
  output logic signed [31:0] data_out_o,
  output logic        [6:0]  list_count_o,
  output logic        [1:0]  status_o
);
  import olids_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  logic [31:0]   mem_q [CAPACITY];
  logic [31:0]   rdata_q;
  logic [31:0]   wdata;

  logic [2:0]    mode_q;
  logic [6:0]    pos_q;
  logic [31:0]   val_q;

  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_p1, idx_m1, raddr;
  logic [PW-1:0] pos_w, len_w, len_p1, idx_pw1;

  logic [6:0]    res_found_q;
  logic [31:0]   res_data_q;
  status_e       res_status_q;

  logic          out_valid_q;
  logic [6:0]    out_found_q;
  logic [31:0]   out_data_q;
  logic [6:0]    out_count_q;
  status_e       out_status_q;

  // latched item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= item_value_i;
    end
  end

  assign pos_w   = PW'(pos_q);
  assign len_w   = PW'(len_q);
  assign len_p1  = len_w + PW'(1);
  assign idx_pw1 = PW'(idx_q) + PW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign idx_m1  = idx_q - CW'(1);

  always_comb begin
    unique case (cmd_i.len_op)
      LEN_HOLD:  len_d = len_q;
      LEN_CLEAR: len_d = '0;
      LEN_INC:   len_d = len_q + CW'(1);
      LEN_DEC:   len_d = len_q - CW'(1);
    endcase
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_LEN:   idx_d = len_q;
      IDX_POSM1: idx_d = CW'(pos_w - PW'(1));
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_p1;
      IDX_DEC:   idx_d = idx_m1;
      default:   idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_IDX:   raddr = idx_q;
      RA_IDXP1: raddr = idx_p1;
      RA_IDXM1: raddr = idx_m1;
      default:  raddr = idx_q;
    endcase
  end

  assign wdata = (cmd_i.wd_sel == WD_RDATA) ? rdata_q : val_q;

  // element memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[idx_q[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.mode     = mode_e'(mode_q);
    sts_o.full     = (len_q == CW'(CAPACITY));
    sts_o.ins_bad  = (pos_w == '0) || (pos_w > len_p1);
    sts_o.acc_bad  = (pos_w == '0) || (pos_w > len_w);
    sts_o.len_zero = (len_q == '0);
    sts_o.last     = (idx_pw1 == len_w);
    sts_o.at_pos   = (idx_pw1 == pos_w);
    sts_o.match    = (rdata_q == val_q);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // result being built for the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_found_q  <= '0;
      res_data_q   <= '0;
      res_status_q <= ST_OK;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.set_found) begin
        res_found_q <= idx_pw1[6:0];
      end
      if (cmd_i.set_data) begin
        res_data_q <= rdata_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_found_q  <= res_found_q;
      out_data_q   <= res_data_q;
      out_count_q  <= len_w[6:0];
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_position_o = out_found_q;
  assign data_out_o       = out_data_q;
  assign list_count_o     = out_count_q;
  assign status_o         = out_status_q;

endmodule

FILE: design/ordered_list_insert_delete_search.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries kept in a single-port element memory,
// driven by a sequencer that does one memory read or one memory write per cycle. Clear, unused
// modes and rejected operations (full list, bad position) go straight to the result; locate
// compares entries from the first until a match or the last entry, insert shifts the entries
// from the end down to the position up by one before writing the item, and delete captures the
// entry at the position and moves each later entry down by one. Each moved or compared entry
// needs a read and then a write or compare on the memory port. A new item is taken the cycle
// after the previous result is registered, while that result still waits on the output side.
// The memory needs no initialization: entries are only read inside the current length.
module ordered_list_insert_delete_search #(
  parameter int CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  olids_in_if.sink      in_i,
  olids_out_if.source   out_o
);
  import olids_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olids_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olids_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (in_i.mode),
    .position_i       (in_i.position),
    .item_value_i     (in_i.item_value),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .found_position_o (out_o.found_position),
    .data_out_o       (out_o.data_out),
    .list_count_o     (out_o.list_count),
    .status_o         (out_o.status)
  );

endmodule

FILE: design/olids_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module olids_chk #(
  parameter int CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  found_position_i,
  input logic [31:0] data_out_i,
  input logic [6:0]  list_count_i,
  input logic [1:0]  status_i
);
  import olids_pkg::*;

  // result item holds until taken
  `OLIDS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `OLIDS_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(data_out_i) && $stable(list_count_i) && $stable(status_i))

  // full report only with a full list
  `OLIDS_ASSERT(a_full_count, out_valid_i && (status_i == ST_FULL) |-> (list_count_i == 7'(CAPACITY)))

  // failed operations return no data and no position
  `OLIDS_ASSERT(a_fail_zero, out_valid_i && (status_i != ST_OK) |-> (data_out_i == '0) && (found_position_i == '0))

  // a hit never carries data
  `OLIDS_ASSERT(a_found_clean, out_valid_i && (found_position_i != '0) |-> (data_out_i == '0) && (status_i == ST_OK))

endmodule

bind ordered_list_insert_delete_search olids_chk #(
  .CAPACITY (CAPACITY)
) u_olids_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .found_position_i (out_o.found_position),
  .data_out_i       (out_o.data_out),
  .list_count_i     (out_o.list_count),
  .status_i         (out_o.status)
);
